// ----- rtl/tscc_pkg.sv -----
// shared constants and types for the continuity counter restamp unit
`timescale 1ns / 1ps
`default_nettype none

package tscc_pkg;

    // sizes of the pid table and of one transport packet
    localparam int TABLE_ENTRIES = 32;
    localparam int PACKET_BYTES  = 188;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // field widths
    localparam int PID_W  = 13;
    localparam int BYTE_W = 8;
    localparam int CC_W   = 4;
    localparam int POS_W  = 8;
    localparam int LDIX_W = 5;

    // stream constants
    localparam logic [PID_W-1:0]  NULL_PID      = 13'h1fff;
    localparam logic [4:0]        PID_HIGH_MASK = 5'h1f;
    localparam logic [BYTE_W-1:0] HIGH_NIBBLE   = 8'hf0;
    localparam logic [CC_W-1:0]   CC_MAX        = 4'd15;

    // item kinds
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_BYTE = 1'b1;

    // queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // classified item handed from front to back
    typedef struct packed {
        logic                is_load;
        logic [IDX_W-1:0]    idx;
        logic [PID_W-1:0]    pid;
        logic [BYTE_W-1:0]   data;
        logic                restamp;
        logic                last;
    } tscc_work_t;

endpackage

`default_nettype wire

// ----- rtl/tscc_front.sv -----
// front part: tracks packet position, captures the pid, classifies items
`timescale 1ns / 1ps
`default_nettype none

module tscc_front
    import tscc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                action,
    input  wire logic [LDIX_W-1:0]   entry_index,
    input  wire logic [PID_W-1:0]    entry_pid,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                q_full,
    output logic                     q_push,
    output tscc_work_t               q_item
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [PID_W-1:0] pid_reg, pid_next;
    logic             accept;
    logic             in_range;
    logic             last;

    assign accept   = push && !q_full;
    assign in_range = int'(entry_index) < TABLE_ENTRIES;
    assign last     = pos_reg >= POS_W'(PACKET_BYTES - 1);

    // classify the item and build the queue entry
    always_comb
    begin
        q_item.is_load = (action == ACTION_LOAD);
        q_item.idx     = IDX_W'(entry_index);
        q_item.pid     = (action == ACTION_LOAD) ? entry_pid : pid_reg;
        q_item.data    = data_byte;
        q_item.restamp = (pos_reg == POS_W'(3)) && (pid_reg != NULL_PID);
        q_item.last    = last;
        q_push         = accept && ((action == ACTION_BYTE) || in_range);
    end

    // byte position and pid capture, loads leave them alone
    always_comb
    begin
        pos_next = pos_reg;
        pid_next = pid_reg;
        if (accept && (action == ACTION_BYTE))
        begin
            pos_next = last ? '0 : pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(1))
            begin
                pid_next = {data_byte[4:0] & PID_HIGH_MASK, 8'h00};
            end
            else if (pos_reg == POS_W'(2))
            begin
                pid_next = {pid_reg[PID_W-1:8], data_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            pid_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            pid_reg <= pid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tscc_queue.sv -----
// short first-in first-out queue of classified items
`timescale 1ns / 1ps
`default_nettype none

module tscc_queue
    import tscc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire tscc_work_t  wr_item,
    output logic             full,
    input  wire logic        rd_en,
    output tscc_work_t       rd_item,
    output logic             empty
);

    tscc_work_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_item = slot_reg[rptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and fill count update
    always_comb
    begin
        wptr_next = do_wr ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = do_rd ? rptr_reg + QPTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_item;
        end
    end

    // fill count never passes the depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    // pointers stay apart by exactly the fill count
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wptr_reg - rptr_reg) == QPTR_W'(cnt_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- rtl/tscc_back.sv -----
// back part: pid table, counter restamp and result buffer
`timescale 1ns / 1ps
`default_nettype none

module tscc_back
    import tscc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire tscc_work_t          q_item,
    output logic                     q_pop,
    output logic                     empty,
    input  wire logic                pop,
    output logic [BYTE_W-1:0]        out_byte,
    output logic                     unknown_pid,
    output logic                     packet_last
);

    // table state
    logic [PID_W-1:0]         pid_table_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CC_W-1:0]          cc_reg [TABLE_ENTRIES];

    // two-entry result buffer
    logic [BYTE_W-1:0]        ob_byte_reg [2];
    logic                     ob_unk_reg  [2];
    logic                     ob_last_reg [2];
    logic                     ob_wptr_reg, ob_rptr_reg;
    logic [1:0]               ob_cnt_reg, ob_cnt_next;

    logic [TABLE_ENTRIES-1:0] hit;
    logic [TABLE_ENTRIES-1:0] first_hit;
    logic [TABLE_ENTRIES-1:0] cc_wr;
    logic [CC_W-1:0]          cc_sel;
    logic [CC_W-1:0]          cc_new;
    logic                     found;
    logic                     ob_room;
    logic                     ob_push;
    logic                     ob_pop;
    logic [BYTE_W-1:0]        res_byte;
    logic                     res_unk;

    // output side handshake
    assign empty       = (ob_cnt_reg == 2'd0);
    assign ob_pop      = pop && !empty;
    assign ob_room     = (ob_cnt_reg != 2'd2) || ob_pop;
    assign out_byte    = ob_byte_reg[ob_rptr_reg];
    assign unknown_pid = ob_unk_reg[ob_rptr_reg];
    assign packet_last = ob_last_reg[ob_rptr_reg];

    // loads need no result slot, stream bytes do
    assign q_pop   = !q_empty && (q_item.is_load || ob_room);
    assign ob_push = q_pop && !q_item.is_load;

    // parallel pid match against every valid entry
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit[i] = valid_reg[i] && (pid_table_reg[i] == q_item.pid);
        end
    end

    // lowest matching entry wins
    assign first_hit = hit & (~hit + TABLE_ENTRIES'(1));
    assign found     = |hit;

    // pick that entry's counter and advance it
    always_comb
    begin
        cc_sel = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            cc_sel = cc_sel | (cc_reg[i] & {CC_W{first_hit[i]}});
        end
    end

    assign cc_new = (cc_sel == CC_MAX) ? '0 : cc_sel + CC_W'(1);
    assign cc_wr  = (ob_push && q_item.restamp) ? first_hit : '0;

    // result item
    always_comb
    begin
        res_byte = q_item.data;
        res_unk  = 1'b0;
        if (q_item.restamp)
        begin
            if (found)
            begin
                res_byte = (q_item.data & HIGH_NIBBLE) | {{(BYTE_W-CC_W){1'b0}}, cc_new};
            end
            else
            begin
                res_unk = 1'b1;
            end
        end
    end

    // table pid storage, entries are only compared once valid
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.is_load)
        begin
            pid_table_reg[q_item.idx] <= q_item.pid;
        end
    end

    // valid bits and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                cc_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (q_pop && q_item.is_load && (q_item.idx == IDX_W'(i)))
                begin
                    valid_reg[i] <= 1'b1;
                    cc_reg[i]    <= '0;
                end
                else if (cc_wr[i])
                begin
                    cc_reg[i] <= cc_new;
                end
            end
        end
    end

    // result buffer control
    always_comb
    begin
        ob_cnt_next = ob_cnt_reg;
        if (ob_push && !ob_pop)
        begin
            ob_cnt_next = ob_cnt_reg + 2'd1;
        end
        else if (ob_pop && !ob_push)
        begin
            ob_cnt_next = ob_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wptr_reg <= 1'b0;
            ob_rptr_reg <= 1'b0;
            ob_cnt_reg  <= 2'd0;
        end
        else
        begin
            ob_cnt_reg <= ob_cnt_next;
            if (ob_push)
            begin
                ob_wptr_reg <= ~ob_wptr_reg;
            end
            if (ob_pop)
            begin
                ob_rptr_reg <= ~ob_rptr_reg;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (ob_push)
        begin
            ob_byte_reg[ob_wptr_reg] <= res_byte;
            ob_unk_reg[ob_wptr_reg]  <= res_unk;
            ob_last_reg[ob_wptr_reg] <= q_item.last;
        end
    end

    // at most one counter advances per cycle
    a_one_cc: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cc_wr))
        else $error("more than one counter advanced");

    // result buffer never overfills
    a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ob_cnt_reg <= 2'd2)
        else $error("result buffer overflow");

endmodule

`default_nettype wire

// ----- rtl/ts_continuity_counter_restamp_unit.sv -----
// Top level of the transport stream continuity counter restamp unit.
// Input channel is queue-like: an item is taken when push is high and full
// is low. action selects a pid table load (entry_index, entry_pid) or a
// stream byte (data_byte). Loads produce no result; every stream byte
// produces one result item (out_byte, unknown_pid, packet_last).
// Result channel: while empty is low the oldest result is on the ports and
// is taken when pop is high. The front tracks the packet byte position and
// the pid, a four-item queue decouples it from the back, which matches the
// pid against all table entries in parallel and restamps header byte 3.
// A taken byte is registered in the queue, then moved into the result
// buffer and shown on the result ports; stalls on either side hold it.
// Throughput: one item per cycle while the result buffer has room, set by
// the parallel table match and counter update in the back.
// Reset clears the byte position, captured pid, valid bits, counters and
// both queues; table pid values are undefined until loaded.
// When the receiver stalls, the two-entry result buffer and then the
// four-item queue fill, after which full rises and input stalls.
`timescale 1ns / 1ps
`default_nettype none

module ts_continuity_counter_restamp_unit
    import tscc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                action,
    input  wire logic [LDIX_W-1:0]   entry_index,
    input  wire logic [PID_W-1:0]    entry_pid,
    input  wire logic [BYTE_W-1:0]   data_byte,
    output logic                     empty,
    input  wire logic                pop,
    output logic [BYTE_W-1:0]        out_byte,
    output logic                     unknown_pid,
    output logic                     packet_last
);

    tscc_work_t wr_item;
    tscc_work_t rd_item;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    assign full = q_full;

    // classify incoming items
    tscc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .action      (action),
        .entry_index (entry_index),
        .entry_pid   (entry_pid),
        .data_byte   (data_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (wr_item)
    );

    // decoupling queue
    tscc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (wr_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (rd_item),
        .empty   (q_empty)
    );

    // table match, restamp and result buffer
    tscc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (rd_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .unknown_pid (unknown_pid),
        .packet_last (packet_last)
    );

endmodule

`default_nettype wire
